FILE: rtl/core/triangle_tangent_frame_macros.svh
// Assertion macros shared by the tangent frame RTL.
// Each macro expects signals clk and rst_n in the including module.
`ifndef TRIANGLE_TANGENT_FRAME_MACROS_SVH
`define TRIANGLE_TANGENT_FRAME_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TTF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TTF_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/ttf_pkg.sv
// Shared types, constants and helpers of the triangle tangent frame block.
// No dependencies; every RTL module imports this package.
package ttf_pkg;

    localparam int COORD_WIDTH  = 32;
    localparam int FRAC_BITS    = 16;
    localparam int DELTA_W      = COORD_WIDTH + 1;
    localparam int PROD_W       = 2 * DELTA_W;
    localparam int NUM_W        = PROD_W + 1;
    localparam int EXT_W        = NUM_W + COORD_WIDTH;
    localparam int BITCNT_W     = $clog2(COORD_WIDTH + 1);
    localparam int IN_W         = 5 * COORD_WIDTH;
    localparam int IN_TDATA_W   = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W        = 6 * COORD_WIDTH;
    localparam int OUT_TDATA_W  = ((OUT_W + 7) / 8) * 8;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int NUM_COMPS    = 6;
    localparam int COMP_W       = $clog2(NUM_COMPS);
    localparam int AXIS_COMPS   = 3;

    localparam logic [COMP_W-1:0] LAST_COMP      = COMP_W'(NUM_COMPS - 1);
    localparam logic [COMP_W-1:0] FIRST_BITAN    = COMP_W'(AXIS_COMPS);
    localparam logic [1:0]        CORNER_FIRST   = 2'd0;
    localparam logic [1:0]        CORNER_SECOND  = 2'd1;
    localparam logic [1:0]        CORNER_THIRD   = 2'd2;
    localparam logic [1:0]        LAST_EMIT      = 2'd2;

    typedef logic [COORD_WIDTH-1:0] coord_t;
    typedef logic [DELTA_W-1:0]     delta_t;

    // Packed so that pos_x sits in the lowest bits.
    typedef struct packed {
        coord_t tex_v;
        coord_t tex_u;
        coord_t pos_z;
        coord_t pos_y;
        coord_t pos_x;
    } vertex_t;

    // Edge and UV deltas of one triangle, handed from front to back.
    typedef struct packed {
        logic [AXIS_COMPS-1:0][DELTA_W-1:0] dp1;
        logic [AXIS_COMPS-1:0][DELTA_W-1:0] dp2;
        delta_t du1;
        delta_t dv1;
        delta_t du2;
        delta_t dv2;
    } job_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DET_A,
        ST_DET_B,
        ST_DET_C,
        ST_NUM_A,
        ST_NUM_B,
        ST_NUM_C,
        ST_DIV_SET,
        ST_DIV,
        ST_SAT,
        ST_EMIT
    } back_state_t;

    // Exact difference of two signed coordinates, one bit wider.
    function automatic delta_t sub_ext(coord_t a, coord_t b);
        return {a[COORD_WIDTH-1], a} - {b[COORD_WIDTH-1], b};
    endfunction

endpackage

FILE: rtl/core/ttf_front.sv
// Front end: takes vertices, keeps the first two corners, forms the deltas.
// Depends on ttf_pkg.
module ttf_front (
    input  logic             clk,
    input  logic             rst_n,
    input  ttf_pkg::vertex_t vtx,
    input  logic             vtx_valid,
    output logic             vtx_ready,
    output ttf_pkg::job_t    job,
    output logic             job_valid,
    input  logic             job_ready
);
    import ttf_pkg::*;

    logic [1:0] cnt_reg, cnt_next;
    vertex_t    first_reg, second_reg;
    logic       third;
    logic       accept;

    // Any count of two or more closes the triangle.
    assign third     = cnt_reg[1];
    assign vtx_ready = !third || job_ready;
    assign job_valid = vtx_valid && third;
    assign accept    = vtx_valid && vtx_ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (accept)
        begin
            case (cnt_reg)
                CORNER_FIRST:  cnt_next = CORNER_SECOND;
                CORNER_SECOND: cnt_next = CORNER_THIRD;
                default:       cnt_next = CORNER_FIRST;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= CORNER_FIRST;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && cnt_reg == CORNER_FIRST)
        begin
            first_reg <= vtx;
        end
        if (accept && cnt_reg == CORNER_SECOND)
        begin
            second_reg <= vtx;
        end
    end

    always_comb
    begin
        job.dp1[0] = sub_ext(second_reg.pos_x, first_reg.pos_x);
        job.dp1[1] = sub_ext(second_reg.pos_y, first_reg.pos_y);
        job.dp1[2] = sub_ext(second_reg.pos_z, first_reg.pos_z);
        job.dp2[0] = sub_ext(vtx.pos_x, first_reg.pos_x);
        job.dp2[1] = sub_ext(vtx.pos_y, first_reg.pos_y);
        job.dp2[2] = sub_ext(vtx.pos_z, first_reg.pos_z);
        job.du1    = sub_ext(second_reg.tex_u, first_reg.tex_u);
        job.dv1    = sub_ext(second_reg.tex_v, first_reg.tex_v);
        job.du2    = sub_ext(vtx.tex_u, first_reg.tex_u);
        job.dv2    = sub_ext(vtx.tex_v, first_reg.tex_v);
    end

endmodule

FILE: rtl/core/ttf_queue.sv
// Short queue of triangle jobs between the front and back ends.
// Depends on ttf_pkg.
module ttf_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  ttf_pkg::job_t push_job,
    input  logic          push_valid,
    output logic          push_ready,
    output ttf_pkg::job_t pop_job,
    output logic          pop_valid,
    input  logic          pop_ready
);
    import ttf_pkg::*;

    job_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_job    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

FILE: rtl/core/ttf_back.sv
// Back end: shared multiplier, shared radix-2 divider and the result words.
// Depends on ttf_pkg and triangle_tangent_frame_macros.svh.
`include "triangle_tangent_frame_macros.svh"

module ttf_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ttf_pkg::job_t                       job,
    input  logic                                job_valid,
    output logic                                job_ready,
    output logic [ttf_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic                                m_tuser,
    output logic                                m_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready
);
    import ttf_pkg::*;

    back_state_t                  state_reg, state_next;
    job_t                         job_reg, job_next;
    logic signed [PROD_W-1:0]     prod_reg, prod_next;
    logic signed [PROD_W-1:0]     first_reg, first_next;
    logic [NUM_W-1:0]             det_mag_reg, det_mag_next;
    logic                         det_neg_reg, det_neg_next;
    logic [NUM_W-1:0]             num_reg, num_next;
    logic                         neg_reg, neg_next;
    logic                         ovf_reg, ovf_next;
    logic [NUM_W-1:0]             rem_reg, rem_next;
    logic [COORD_WIDTH-1:0]       low_reg, low_next;
    logic [COORD_WIDTH-1:0]       q_reg, q_next;
    logic [BITCNT_W-1:0]          bit_cnt_reg, bit_cnt_next;
    logic [COMP_W-1:0]            comp_reg, comp_next;
    logic [NUM_COMPS-1:0][COORD_WIDTH-1:0] res_reg, res_next;
    logic                         degen_reg, degen_next;
    logic [1:0]                   emit_reg, emit_next;

    logic [DELTA_W-1:0]           opa, opb;
    logic [1:0]                   axis;
    logic                         is_bitan;
    logic [NUM_W-1:0]             diff;
    logic [NUM_W-1:0]             nmag;
    logic [EXT_W-1:0]             nsh, dsh;
    logic [NUM_W:0]               trial;
    logic [COORD_WIDTH-1:0]       sat_val;

    assign is_bitan = comp_reg >= FIRST_BITAN;
    assign axis     = is_bitan ? 2'(comp_reg - FIRST_BITAN) : comp_reg[1:0];

    // Operand selection for the one multiplier.
    always_comb
    begin
        opa = job_reg.du1;
        opb = job_reg.dv2;
        case (state_reg)
            ST_DET_B:
            begin
                opa = job_reg.dv1;
                opb = job_reg.du2;
            end
            ST_NUM_A:
            begin
                opa = is_bitan ? job_reg.dp2[axis] : job_reg.dp1[axis];
                opb = is_bitan ? job_reg.du1 : job_reg.dv2;
            end
            ST_NUM_B:
            begin
                opa = is_bitan ? job_reg.dp1[axis] : job_reg.dp2[axis];
                opb = is_bitan ? job_reg.du2 : job_reg.dv1;
            end
            default:
            begin
                opa = job_reg.du1;
                opb = job_reg.dv2;
            end
        endcase
    end

    assign diff = {first_reg[PROD_W-1], first_reg} - {prod_reg[PROD_W-1], prod_reg};
    assign nmag = num_reg[NUM_W-1] ? -num_reg : num_reg;
    assign nsh  = EXT_W'(nmag) << FRAC_BITS;
    assign dsh  = EXT_W'(det_mag_reg) << COORD_WIDTH;
    assign trial = {rem_reg, low_reg[COORD_WIDTH-1]} - {1'b0, det_mag_reg};

    // Truncated quotient saturated to the signed coordinate range.
    always_comb
    begin
        if (ovf_reg)
        begin
            sat_val = neg_reg ? {1'b1, {(COORD_WIDTH-1){1'b0}}}
                              : {1'b0, {(COORD_WIDTH-1){1'b1}}};
        end
        else if (!neg_reg)
        begin
            sat_val = q_reg[COORD_WIDTH-1] ? {1'b0, {(COORD_WIDTH-1){1'b1}}} : q_reg;
        end
        else
        begin
            sat_val = (q_reg > {1'b1, {(COORD_WIDTH-1){1'b0}}})
                      ? {1'b1, {(COORD_WIDTH-1){1'b0}}} : -q_reg;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        job_next     = job_reg;
        prod_next    = prod_reg;
        first_next   = first_reg;
        det_mag_next = det_mag_reg;
        det_neg_next = det_neg_reg;
        num_next     = num_reg;
        neg_next     = neg_reg;
        ovf_next     = ovf_reg;
        rem_next     = rem_reg;
        low_next     = low_reg;
        q_next       = q_reg;
        bit_cnt_next = bit_cnt_reg;
        comp_next    = comp_reg;
        res_next     = res_reg;
        degen_next   = degen_reg;
        emit_next    = emit_reg;
        job_ready    = 1'b0;
        m_tvalid     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                job_ready = 1'b1;
                if (job_valid)
                begin
                    job_next   = job;
                    state_next = ST_DET_A;
                end
            end
            ST_DET_A:
            begin
                prod_next  = $signed(opa) * $signed(opb);
                state_next = ST_DET_B;
            end
            ST_DET_B:
            begin
                first_next = prod_reg;
                prod_next  = $signed(opa) * $signed(opb);
                state_next = ST_DET_C;
            end
            ST_DET_C:
            begin
                if (diff == '0)
                begin
                    degen_next = 1'b1;
                    res_next   = '0;
                    emit_next  = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    degen_next   = 1'b0;
                    det_neg_next = diff[NUM_W-1];
                    det_mag_next = diff[NUM_W-1] ? -diff : diff;
                    comp_next    = '0;
                    state_next   = ST_NUM_A;
                end
            end
            ST_NUM_A:
            begin
                prod_next  = $signed(opa) * $signed(opb);
                state_next = ST_NUM_B;
            end
            ST_NUM_B:
            begin
                first_next = prod_reg;
                prod_next  = $signed(opa) * $signed(opb);
                state_next = ST_NUM_C;
            end
            ST_NUM_C:
            begin
                num_next   = diff;
                state_next = ST_DIV_SET;
            end
            ST_DIV_SET:
            begin
                // Quotients of 2^COORD_WIDTH or more saturate without dividing.
                neg_next     = num_reg[NUM_W-1] ^ det_neg_reg;
                ovf_next     = nsh >= dsh;
                rem_next     = NUM_W'(nsh >> COORD_WIDTH);
                low_next     = nsh[COORD_WIDTH-1:0];
                q_next       = '0;
                bit_cnt_next = BITCNT_W'(COORD_WIDTH);
                state_next   = (nsh >= dsh) ? ST_SAT : ST_DIV;
            end
            ST_DIV:
            begin
                if (!trial[NUM_W])
                begin
                    rem_next = trial[NUM_W-1:0];
                    q_next   = {q_reg[COORD_WIDTH-2:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[NUM_W-2:0], low_reg[COORD_WIDTH-1]};
                    q_next   = {q_reg[COORD_WIDTH-2:0], 1'b0};
                end
                low_next     = {low_reg[COORD_WIDTH-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg - 1'b1;
                if (bit_cnt_reg == BITCNT_W'(1))
                begin
                    state_next = ST_SAT;
                end
            end
            ST_SAT:
            begin
                res_next[comp_reg] = sat_val;
                if (comp_reg == LAST_COMP)
                begin
                    emit_next  = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    comp_next  = comp_reg + 1'b1;
                    state_next = ST_NUM_A;
                end
            end
            ST_EMIT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    if (emit_reg == LAST_EMIT)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        emit_next = emit_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            emit_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            emit_reg  <= emit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg     <= job_next;
        prod_reg    <= prod_next;
        first_reg   <= first_next;
        det_mag_reg <= det_mag_next;
        det_neg_reg <= det_neg_next;
        num_reg     <= num_next;
        neg_reg     <= neg_next;
        ovf_reg     <= ovf_next;
        rem_reg     <= rem_next;
        low_reg     <= low_next;
        q_reg       <= q_next;
        bit_cnt_reg <= bit_cnt_next;
        comp_reg    <= comp_next;
        res_reg     <= res_next;
        degen_reg   <= degen_next;
    end

    assign m_tdata = OUT_TDATA_W'(res_reg);
    assign m_tuser = degen_reg;
    assign m_tlast = emit_reg == LAST_EMIT;

    `TTF_ASSERT_IMP(a_div_det_nonzero, state_reg == ST_DIV, det_mag_reg != '0, "divide by zero")
    `TTF_ASSERT_IMP(a_degen_zero, m_tvalid && degen_reg, res_reg == '0, "degenerate not zero")
    `TTF_ASSERT_NXT(a_emit_start, state_reg == ST_SAT && comp_reg == LAST_COMP,
                    state_reg == ST_EMIT && emit_reg == '0, "emit did not start at first word")

endmodule

FILE: rtl/core/triangle_tangent_frame.sv
// Triangle tangent frame: top level that joins front end, job queue and back end.
// Depends on ttf_pkg, ttf_front, ttf_queue and ttf_back.
//
// Vertices of a triangle list enter one word at a time; every third vertex
// closes a triangle, whose tangent and bitangent leave as three identical
// words, the third marked by tlast. Operands are signed Q16.16. The front end
// accepts a vertex every cycle, stalling a triangle's third vertex while the
// job queue is full, and forms the edge and UV deltas exactly; a two-entry
// job queue lets it run ahead while the back end works. The back end has one
// 33 by 33 bit multiplier and one restoring divider that yields one quotient
// bit a cycle. A triangle steps through taking its job, the UV determinant
// from two products and, for each of its six components, two products and
// their difference, divider setup, the divide (skipped when the quotient is
// known to saturate) and saturation, then 3 output words. Quotients are
// truncated toward zero and saturated. A zero UV determinant gives zero
// vectors with the degenerate flag in tuser.
module triangle_tangent_frame (
    input  logic                              clk,
    input  logic                              rst_n,
    // s_tdata, from bit 0 up: pos_x, pos_y, pos_z, tex_u, tex_v.
    input  logic [ttf_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // m_tdata, from bit 0 up: tangent_x, tangent_y, tangent_z,
    // bitangent_x, bitangent_y, bitangent_z.
    output logic [ttf_pkg::OUT_TDATA_W-1:0]   m_tdata,
    // m_tuser: degenerate.
    output logic                              m_tuser,
    // m_tlast: last_of_triangle.
    output logic                              m_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready
);
    import ttf_pkg::*;

    vertex_t vtx;
    job_t    front_job, back_job;
    logic    front_valid, front_ready;
    logic    back_valid, back_ready;

    // Padding bits of s_tdata above the five fields are ignored.
    assign vtx = vertex_t'(s_tdata[IN_W-1:0]);

    ttf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .vtx       (vtx),
        .vtx_valid (s_tvalid),
        .vtx_ready (s_tready),
        .job       (front_job),
        .job_valid (front_valid),
        .job_ready (front_ready)
    );

    ttf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_job   (front_job),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_job    (back_job),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready)
    );

    ttf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (back_job),
        .job_valid (back_valid),
        .job_ready (back_ready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready)
    );

endmodule

FILE: bench/triangle_tangent_frame_checker.sv
// Checker for the triangle tangent frame block: watches both stream channels,
// predicts the tangent and bitangent of each triangle and compares words.
// Depends on ttf_pkg.
module triangle_tangent_frame_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [ttf_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [ttf_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                            m_tuser,
    input  logic                            m_tlast,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    output int                              fail_count,
    output int                              pending_words
);
    import ttf_pkg::*;

    typedef struct {
        logic [OUT_W-1:0] vectors;
        logic             degenerate;
        logic             last;
    } frame_word_t;

    frame_word_t frame_queue[$];
    vertex_t     corner0;
    vertex_t     corner1;
    logic [1:0]  corners_held;

    assign pending_words = frame_queue.size();

    task automatic report_mismatch(input string what);
        fail_count++;
        $display("ERROR at %0t: %s", $realtime, what);
    endtask

    // Exact quotient (num << FRAC_BITS) / det truncated toward zero, saturated.
    function automatic coord_t divide_saturate(logic signed [127:0] num,
                                               logic signed [127:0] det);
        logic signed [127:0] q;
        logic signed [127:0] maxv;
        q = (num <<< FRAC_BITS) / det;
        maxv = (128'sd1 <<< (COORD_WIDTH - 1)) - 1;
        if (q > maxv)
            return coord_t'(maxv);
        if (q < -maxv - 1)
            return coord_t'(-maxv - 1);
        return coord_t'(q);
    endfunction

    task automatic predict_triangle(input vertex_t c2);
        logic signed [127:0] p0[5];
        logic signed [127:0] p1[5];
        logic signed [127:0] p2[5];
        logic signed [127:0] dp1[3];
        logic signed [127:0] dp2[3];
        logic signed [127:0] du1, dv1, du2, dv2, det;
        logic [OUT_W-1:0]    vec;
        frame_word_t         w;
        vec = '0;
        for (int i = 0; i < 5; i++)
        begin
            p0[i] = 128'(signed'(corner0[i*COORD_WIDTH +: COORD_WIDTH]));
            p1[i] = 128'(signed'(corner1[i*COORD_WIDTH +: COORD_WIDTH]));
            p2[i] = 128'(signed'(c2[i*COORD_WIDTH +: COORD_WIDTH]));
        end
        for (int i = 0; i < 3; i++)
        begin
            dp1[i] = p1[i] - p0[i];
            dp2[i] = p2[i] - p0[i];
        end
        du1 = p1[3] - p0[3];
        dv1 = p1[4] - p0[4];
        du2 = p2[3] - p0[3];
        dv2 = p2[4] - p0[4];
        det = du1 * dv2 - dv1 * du2;
        w.degenerate = (det == 0);
        if (det != 0)
        begin
            for (int i = 0; i < 3; i++)
            begin
                vec[i*COORD_WIDTH +: COORD_WIDTH] =
                    divide_saturate(dp1[i] * dv2 - dp2[i] * dv1, det);
                vec[(3+i)*COORD_WIDTH +: COORD_WIDTH] =
                    divide_saturate(dp2[i] * du1 - dp1[i] * du2, det);
            end
        end
        w.vectors = vec;
        for (int k = 0; k < 3; k++)
        begin
            w.last = (k == 2);
            frame_queue = {frame_queue, w};
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corners_held = CORNER_FIRST;
            fail_count   = 0;
            frame_queue.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (frame_queue.size() == 0)
                    report_mismatch("result word with none expected");
                else
                begin
                    frame_word_t e;
                    e = frame_queue.pop_front();
                    for (int i = 0; i < 6; i++)
                        if (m_tdata[i*COORD_WIDTH +: COORD_WIDTH]
                            !== e.vectors[i*COORD_WIDTH +: COORD_WIDTH])
                            report_mismatch($sformatf("component %0d: got %h, want %h", i,
                                m_tdata[i*COORD_WIDTH +: COORD_WIDTH],
                                e.vectors[i*COORD_WIDTH +: COORD_WIDTH]));
                    if (m_tuser !== e.degenerate)
                        report_mismatch($sformatf("degenerate: got %b, want %b",
                            m_tuser, e.degenerate));
                    if (m_tlast !== e.last)
                        report_mismatch($sformatf("last: got %b, want %b",
                            m_tlast, e.last));
                end
            end
            if (s_tvalid && s_tready)
            begin
                if (corners_held == CORNER_FIRST)
                begin
                    corner0 = s_tdata[IN_W-1:0];
                    corners_held = CORNER_SECOND;
                end
                else if (corners_held == CORNER_SECOND)
                begin
                    corner1 = s_tdata[IN_W-1:0];
                    corners_held = CORNER_THIRD;
                end
                else
                begin
                    predict_triangle(s_tdata[IN_W-1:0]);
                    corners_held = CORNER_FIRST;
                end
            end
        end
    end
endmodule

FILE: bench/triangle_tangent_frame_test.sv
// Testbench top for the triangle tangent frame block: drives vertex words with
// random gaps and back-pressure and gives the verdict. Depends on ttf_pkg,
// the block and triangle_tangent_frame_checker.
module triangle_tangent_frame_test;
    import ttf_pkg::*;

    localparam int RANDOM_TRIANGLES = 100;
    localparam int IDLE_LIMIT       = 20000;
    localparam int DRAIN_CYCLES     = 300;

    logic                   clk;
    logic                   rst_n;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;
    logic                   m_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    int                     fail_count;
    int                     pending_words;
    int                     idle_cycles = 0;
    bit                     calm_phase;
    bit                     hold_sink;

    triangle_tangent_frame i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready)
    );

    triangle_tangent_frame_checker i_checker (
        .clk(clk), .rst_n(rst_n),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .fail_count(fail_count), .pending_words(pending_words)
    );

    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Sends one vertex word and waits for its acceptance. An idle burst may
    // come first unless the run is in its calm final stretch.
    task automatic send_vertex(input vertex_t v);
        if (!calm_phase && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        s_tdata  <= IN_TDATA_W'(v);
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Random coordinate: mostly small values so that most quotients are in
    // range, sometimes full-width values to reach saturation.
    function automatic coord_t random_coord();
        case ($urandom_range(0, 9))
            0: return coord_t'($urandom);
            1: return coord_t'($urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7fff_ffff);
            default: return coord_t'(signed'(32'($urandom_range(0, 1 << 22))) - (1 << 21));
        endcase
    endfunction

    function automatic vertex_t random_vertex();
        vertex_t v;
        v.pos_x = random_coord();
        v.pos_y = random_coord();
        v.pos_z = random_coord();
        v.tex_u = random_coord();
        v.tex_v = random_coord();
        return v;
    endfunction

    function automatic vertex_t make_vertex(input coord_t x, input coord_t y,
                                            input coord_t z, input coord_t u,
                                            input coord_t v);
        vertex_t r;
        r.pos_x = x;
        r.pos_y = y;
        r.pos_z = z;
        r.tex_u = u;
        r.tex_v = v;
        return r;
    endfunction

    // The sink stalls in random bursts; a long hold-off from the stimulus
    // process overrides it so that the block fills up.
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_sink)
            begin
                m_tready <= 1'b0;
                @(posedge clk);
            end
            else if (!calm_phase && $urandom_range(0, 2) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    // Long sink hold-off, counted in its own process.
    task automatic hold_sink_for(input int cycles);
        fork
            begin
                hold_sink = 1'b1;
                repeat (cycles) @(posedge clk);
                hold_sink = 1'b0;
            end
        join_none
    endtask

    // Watchdog: cycles in which no word moves on either side.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("** triangle_tangent_frame: FAILED **");
            $finish;
        end
    end

    initial
    begin
        coord_t one;
        one           = coord_t'(1 << FRAC_BITS);
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        calm_phase    = 1'b0;
        hold_sink     = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: a plain unit triangle.
        send_vertex(make_vertex(0, 0, 0, 0, 0));
        send_vertex(make_vertex(one, 0, 0, one, 0));
        send_vertex(make_vertex(0, one, 0, 0, one));
        // Zero determinant: all UVs equal.
        send_vertex(make_vertex(one, 2, 3, 5, 5));
        send_vertex(make_vertex(7, one, 9, 5, 5));
        send_vertex(make_vertex(3, 4, one, 5, 5));
        // Tiny determinant with huge edges: saturates both ways.
        send_vertex(make_vertex(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 0, 0));
        send_vertex(make_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 1, 0));
        send_vertex(make_vertex(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 0, 1));
        // Extreme UVs: largest determinant, truncated quotients.
        send_vertex(make_vertex(32'hffff_ffff, 1, 32'h8000_0000,
                                32'h8000_0000, 32'h7fff_ffff));
        send_vertex(make_vertex(3, 32'hffff_fffd, 7, 32'h7fff_ffff, 32'h8000_0000));
        send_vertex(make_vertex(32'h7fff_ffff, 5, 11, 32'h8000_0000, 32'h8000_0000));
        // Negative quotients that truncate toward zero.
        send_vertex(make_vertex(0, 0, 0, 0, 0));
        send_vertex(make_vertex(32'hffff_fff9, 5, 32'hffff_ffff, 3, 0));
        send_vertex(make_vertex(1, 32'hffff_fffe, 9, 0, 32'hffff_fffd));

        // Let the sink hold off while the sender keeps offering triangles.
        hold_sink_for(3000);
        for (int t = 0; t < 4; t++)
            for (int c = 0; c < 3; c++)
                send_vertex(random_vertex());

        // Sender pause until every expected word has arrived.
        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (pending_words == 0 && !hold_sink);
        @(posedge clk);

        for (int t = 0; t < RANDOM_TRIANGLES; t++)
        begin
            vertex_t v0;
            v0 = random_vertex();
            if (t == RANDOM_TRIANGLES - 15)
                calm_phase = 1'b1;
            send_vertex(v0);
            send_vertex(random_vertex());
            // Occasionally repeat a UV from the first corner to hit a zero
            // determinant with random positions.
            if ($urandom_range(0, 7) == 0)
                send_vertex(make_vertex(random_coord(), random_coord(), random_coord(),
                                        v0.tex_u, v0.tex_v));
            else
                send_vertex(random_vertex());
        end
        s_tvalid <= 1'b0;
        @(posedge clk);

        wait (pending_words == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("** triangle_tangent_frame: PASSED **");
        else
            $display("** triangle_tangent_frame: FAILED **");
        $finish;
    end
endmodule
